// File: rtl/wsfd_pkg.sv
// shared types, constants and helpers of the websocket frame deframer
package wsfd_pkg;

   localparam int LENGTH_WIDTH = 64;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] OP_CONT  = 4'd0;
   localparam logic [3:0] OP_TEXT  = 4'd1;
   localparam logic [3:0] OP_BIN   = 4'd2;
   localparam logic [3:0] OP_CLOSE = 4'd8;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
   localparam logic [1:0] TYPE_TEXT    = 2'd1;
   localparam logic [1:0] TYPE_BINARY  = 2'd2;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic       byte_valid;
      logic [1:0] message_type;
      logic       end_of_message;
      logic       close_seen;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [1:0] type_code(input logic [3:0] opcode);
      logic [1:0] code;
      code = TYPE_UNKNOWN;
      if (opcode == OP_TEXT) begin
         code = TYPE_TEXT;
      end else if (opcode == OP_BIN) begin
         code = TYPE_BINARY;
      end
      return code;
   endfunction

endpackage

// File: rtl/wsfd_if.sv
// valid/ready channel interfaces for received bytes and deframed results
interface wsfd_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface wsfd_rsp_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [1:0] message_type;
   logic       end_of_message;
   logic       close_seen;

   modport source (output valid, output out_byte, output byte_valid, output message_type,
                   output end_of_message, output close_seen, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input message_type,
                 input end_of_message, input close_seen, output ready);
endinterface

// File: rtl/wsfd_front.sv
// frame header parser that turns received bytes into result commands
module wsfd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                in_byte,
   output logic                      push,
   output wsfd_pkg::cmd_type         push_cmd
);

   typedef enum logic [2:0] {
      PH_HEAD0,
      PH_HEAD1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD,
      PH_STOP
   } phase_type;

   phase_type                             phase_ff, phase_in;
   logic [3:0]                            cnt_ff, cnt_in;
   logic                                  final_ff, final_in;
   logic                                  masked_ff, masked_in;
   logic [3:0]                            opcode_ff, opcode_in;
   logic [3:0]                            msg_op_ff, msg_op_in;
   logic [wsfd_pkg::LENGTH_WIDTH-1:0]     rem_ff, rem_in;
   logic [31:0]                           key_ff, key_in;
   logic [1:0]                            kidx_ff, kidx_in;
   logic                                  skip_ff, skip_in;
   logic                                  do_after;
   logic                                  do_finish;
   logic                                  last;
   logic [6:0]                            len7;
   logic [7:0]                            kb;

   always_comb begin
      case (kidx_ff)
         2'd0:    kb = key_ff[31:24];
         2'd1:    kb = key_ff[23:16];
         2'd2:    kb = key_ff[15:8];
         default: kb = key_ff[7:0];
      endcase
   end

   assign len7 = in_byte[6:0];

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      final_in  = final_ff;
      masked_in = masked_ff;
      opcode_in = opcode_ff;
      msg_op_in = msg_op_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      skip_in   = skip_ff;
      do_after  = 1'b0;
      do_finish = 1'b0;
      last      = 1'b0;
      push      = 1'b0;
      push_cmd  = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEAD0: begin
               final_in  = in_byte[7];
               opcode_in = in_byte[3:0];
               phase_in  = PH_HEAD1;
            end
            PH_HEAD1: begin
               masked_in = in_byte[7];
               if (opcode_ff == wsfd_pkg::OP_CLOSE) begin
                  phase_in              = PH_STOP;
                  push                  = 1'b1;
                  push_cmd.close_seen   = 1'b1;
                  push_cmd.message_type = wsfd_pkg::type_code(msg_op_ff);
               end else begin
                  skip_in = (opcode_ff > wsfd_pkg::OP_BIN);
                  if ((len7 == wsfd_pkg::LEN_EXT16) || (len7 == wsfd_pkg::LEN_EXT64)) begin
                     rem_in   = '0;
                     cnt_in   = (len7 == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                              : wsfd_pkg::EXT64_BYTES;
                     phase_in = PH_EXTLEN;
                  end else begin
                     rem_in   = wsfd_pkg::LENGTH_WIDTH'(len7);
                     do_after = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               rem_in = {rem_ff[wsfd_pkg::LENGTH_WIDTH-9:0], in_byte};
               cnt_in = cnt_ff - 4'd1;
               if (cnt_in == 4'd0) begin
                  do_after = 1'b1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], in_byte};
               cnt_in = cnt_ff - 4'd1;
               if (cnt_in == 4'd0) begin
                  do_finish = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               kidx_in = kidx_ff + 2'd1;
               rem_in  = rem_ff - wsfd_pkg::LENGTH_WIDTH'(1);
               last    = (rem_in == '0);
               if (last) begin
                  phase_in = PH_HEAD0;
               end
               if (!skip_ff) begin
                  push                    = 1'b1;
                  push_cmd.data           = in_byte;
                  push_cmd.key            = kb;
                  push_cmd.byte_valid     = 1'b1;
                  push_cmd.message_type   = wsfd_pkg::type_code(msg_op_ff);
                  push_cmd.end_of_message = last && final_ff;
                  if (last && final_ff) begin
                     msg_op_in = wsfd_pkg::OP_CONT;
                  end
               end
            end
            PH_STOP: begin
            end
            default: begin
            end
         endcase
      end
      if (do_after) begin
         key_in = '0;
         if (masked_in) begin
            cnt_in   = wsfd_pkg::KEY_BYTES;
            phase_in = PH_KEY;
         end else begin
            do_finish = 1'b1;
         end
      end
      if (do_finish) begin
         kidx_in = 2'd0;
         if (!skip_in && (msg_op_ff == wsfd_pkg::OP_CONT) && (opcode_ff != wsfd_pkg::OP_CONT)) begin
            msg_op_in = opcode_ff;
         end
         if (rem_in == '0) begin
            phase_in = PH_HEAD0;
            if (!skip_in && final_ff) begin
               push                    = 1'b1;
               push_cmd.end_of_message = 1'b1;
               push_cmd.message_type   = wsfd_pkg::type_code(msg_op_in);
               msg_op_in               = wsfd_pkg::OP_CONT;
            end
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD0;
         cnt_ff    <= '0;
         final_ff  <= 1'b0;
         masked_ff <= 1'b0;
         opcode_ff <= '0;
         msg_op_ff <= '0;
         rem_ff    <= '0;
         key_ff    <= '0;
         kidx_ff   <= '0;
         skip_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         final_ff  <= final_in;
         masked_ff <= masked_in;
         opcode_ff <= opcode_in;
         msg_op_ff <= msg_op_in;
         rem_ff    <= rem_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
         skip_ff   <= skip_in;
      end
   end

   // once stopped the parser never leaves the stop phase
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP) |=> (phase_ff == PH_STOP))
      else $error("parser left stop phase");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP) |-> !push)
      else $error("command issued after close");

   assert property (@(posedge clock) disable iff (reset)
      (push && push_cmd.byte_valid) |-> (phase_ff == PH_PAYLOAD) && !skip_ff)
      else $error("payload byte issued outside a delivered payload");

   assert property (@(posedge clock) disable iff (reset)
      push |-> $countones({push_cmd.byte_valid, push_cmd.close_seen}) <= 1)
      else $error("close command carries a payload byte");

endmodule

// File: rtl/wsfd_queue.sv
// short command queue between the parser and the output stage
module wsfd_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  wsfd_pkg::cmd_type             push_cmd,
   input  logic                          pop,
   output wsfd_pkg::cmd_type             pop_cmd,
   output wsfd_pkg::queue_status_type    status
);

   wsfd_pkg::cmd_type               mem [wsfd_pkg::QUEUE_DEPTH];
   logic [wsfd_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [wsfd_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [wsfd_pkg::QUEUE_AW:0]     count_ff, count_in;

   assign status.full  = (count_ff == (wsfd_pkg::QUEUE_AW+1)'(wsfd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_cmd      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + wsfd_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + wsfd_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (wsfd_pkg::QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (wsfd_pkg::QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (wsfd_pkg::QUEUE_AW+1)'(wsfd_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// File: rtl/wsfd_back.sv
// output stage that unmasks payload bytes and holds each result transaction
module wsfd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  wsfd_pkg::cmd_type             pop_cmd,
   input  wsfd_pkg::queue_status_type    status,
   output logic                          pop,
   wsfd_rsp_if.source                    rsp
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        bvalid_ff;
   logic [1:0]  type_ff;
   logic        eom_ff;
   logic        close_ff;

   assign pop      = !status.empty && (!valid_ff || rsp.ready);
   assign valid_in = pop || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         byte_ff   <= pop_cmd.data ^ pop_cmd.key;
         bvalid_ff <= pop_cmd.byte_valid;
         type_ff   <= pop_cmd.message_type;
         eom_ff    <= pop_cmd.end_of_message;
         close_ff  <= pop_cmd.close_seen;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.out_byte       = byte_ff;
   assign rsp.byte_valid     = bvalid_ff;
   assign rsp.message_type   = type_ff;
   assign rsp.end_of_message = eom_ff;
   assign rsp.close_seen     = close_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp.ready) |-> !pop)
      else $error("held result overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (!valid_ff && !status.empty) |-> pop)
      else $error("output stage idle while commands wait");

   assert property (@(posedge clock) disable iff (reset)
      (pop && pop_cmd.close_seen) |=> !rsp.byte_valid)
      else $error("close result carries a payload byte");

endmodule

// File: rtl/websocket_frame_deframer_core.sv
// top level of the websocket frame deframer
// Takes received bytes and parses WebSocket frames: header, 16 or
// 64 bit extended length, optional masking key, then payload bytes which come
// out unmasked with message type and end of message flags. An empty final data
// frame gives a marker with no byte, a close frame gives one close result and
// stops the parser until reset, and payloads of all other non-data opcodes are
// dropped. A byte is accepted in every cycle while the four-entry command queue
// has room, so the rate is one byte per clock while results are taken; the
// header and length parse is a single registered step per byte. A result passes
// through the command queue into the output register, held there until taken.
module websocket_frame_deframer_core (
   input  logic          clock,
   input  logic          reset,
   wsfd_req_if.sink      req_bus,
   wsfd_rsp_if.source    rsp_bus
);

   logic                          accept;
   logic                          push;
   logic                          pop;
   wsfd_pkg::cmd_type             push_cmd;
   wsfd_pkg::cmd_type             pop_cmd;
   wsfd_pkg::queue_status_type    status;

   assign req_bus.ready = !status.full;
   assign accept        = req_bus.valid && !status.full;

   wsfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_bus.in_byte),
      .push     (push),
      .push_cmd (push_cmd)
   );

   wsfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (status)
   );

   wsfd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .pop_cmd (pop_cmd),
      .status  (status),
      .pop     (pop),
      .rsp     (rsp_bus)
   );

endmodule
